// ===== design/bdel_pkg.sv =====
// Package for the button debounce / edge / long-press block.
// Holds the shared sizes, the opcodes and the input beat type.
// No dependencies.
package bdel_pkg;

   // Sizes
   localparam int NUM_BUTTONS = 6;
   localparam int COUNT_WIDTH = 16;
   localparam int QUERY_W     = 3;
   localparam int THRESH_W    = 16;
   localparam int CMP_W       = 32;

   // Operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Reset values
   localparam logic [THRESH_W-1:0]    LONG_PRESS_RST = THRESH_W'(1000);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = {COUNT_WIDTH{1'b1}};

   // One input beat as held in the input register
   typedef struct packed {
      logic                   op;
      logic [NUM_BUTTONS-1:0] raw_pins;
      logic                   no_filter;
      logic [QUERY_W-1:0]     query_button;
      logic                   query_level;
   } item_type;

endpackage

// ===== design/button_debounce_edge_longpress.sv =====
// Throughput is one beat per clock while the output is not stalled. Each
// beat passes an input register and then a result register, from which its
// result is read when the output is not stalled. The input register and the
// result register are two separate stages, so a new beat is still taken into
// an empty input register while a finished result waits to be read. Sample
// beats (op 0) latch the raw button vector once it repeats
// (or at once with no_filter), flag rising/falling edges and clear the elapsed
// counters of buttons that changed. Tick beats (op 1) advance every counter by
// one millisecond, saturating at all ones; counters start saturated after
// reset. long_press is 1 when the queried button holds the queried level and
// its counter is strictly above long_press_ms (reset value 1000). Write the
// threshold only while no beats are in flight.
//
// File holds the top level of the block; depends on bdel_pkg.
module button_debounce_edge_longpress
   import bdel_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_op,
   input  logic [NUM_BUTTONS-1:0] req_raw_pins,
   input  logic                   req_no_filter,
   input  logic [QUERY_W-1:0]     req_query_button,
   input  logic                   req_query_level,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [NUM_BUTTONS-1:0] rsp_level_bits,
   output logic [NUM_BUTTONS-1:0] rsp_rise_bits,
   output logic [NUM_BUTTONS-1:0] rsp_fall_bits,
   output logic                   rsp_long_press,
   // Threshold register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [THRESH_W-1:0]    csr_long_press_ms
);

   // Handshake and stage control
   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff;
   logic     s2_load;
   logic     s1_load;

   // Block state
   logic [THRESH_W-1:0]    lp_ms_ff;
   logic [NUM_BUTTONS-1:0] level_ff, level_in;
   logic [NUM_BUTTONS-1:0] prev_raw_ff, prev_raw_in;
   logic [NUM_BUTTONS-1:0] rise_ff, rise_in;
   logic [NUM_BUTTONS-1:0] fall_ff, fall_in;
   logic [NUM_BUTTONS-1:0] changed;
   logic [COUNT_WIDTH-1:0] count_ff [NUM_BUTTONS];
   logic [COUNT_WIDTH-1:0] count_in [NUM_BUTTONS];

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NUM_BUTTONS-1:0] rsp_level_ff, rsp_rise_ff, rsp_fall_ff;
   logic                   rsp_lp_ff, lp_in;
   logic [COUNT_WIDTH-1:0] q_count;
   logic                   q_level;

   // Stage 2 moves when the result slot is empty or being taken
   assign s2_load   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s2_load;
   assign s1_load   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = s1_load || (s1_valid_ff && !s2_load);
   assign rsp_valid_in = (s1_valid_ff && s2_load) || (rsp_valid_ff && rsp_stall);

   // Debounce and edge detection on the held beat
   always_comb begin
      level_in    = level_ff;
      prev_raw_in = prev_raw_ff;
      rise_in     = rise_ff;
      fall_in     = fall_ff;
      changed     = '0;
      if (s1_item_ff.op == OP_SAMPLE) begin
         if (s1_item_ff.raw_pins == prev_raw_ff || s1_item_ff.no_filter) begin
            level_in = s1_item_ff.raw_pins;
         end
         prev_raw_in = s1_item_ff.raw_pins;
         changed     = level_in ^ level_ff;
         rise_in     = changed & level_in;
         fall_in     = changed & level_ff;
      end
   end

   // Elapsed counters: clear on edge, saturating count on tick
   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         count_in[i] = count_ff[i];
         if (s1_item_ff.op == OP_TICK) begin
            if (count_ff[i] != COUNT_MAX) begin
               count_in[i] = count_ff[i] + COUNT_WIDTH'(1);
            end
         end else if (changed[i]) begin
            count_in[i] = '0;
         end
      end
   end

   // Long-press query against the updated state
   always_comb begin
      q_count = '0;
      q_level = 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (s1_item_ff.query_button == QUERY_W'(i)) begin
            q_count = count_in[i];
            q_level = level_in[i];
         end
      end
      lp_in = (s1_item_ff.query_button < QUERY_W'(NUM_BUTTONS))
              && (q_level == s1_item_ff.query_level)
              && (CMP_W'(q_count) > CMP_W'(lp_ms_ff));
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lp_ms_ff     <= LONG_PRESS_RST;
         level_ff     <= '1;
         prev_raw_ff  <= '0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            count_ff[i] <= COUNT_MAX;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            lp_ms_ff <= csr_long_press_ms;
         end
         if (s1_valid_ff && s2_load) begin
            level_ff    <= level_in;
            prev_raw_ff <= prev_raw_in;
            rise_ff     <= rise_in;
            fall_ff     <= fall_in;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
               count_ff[i] <= count_in[i];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_item_ff <= '{op: req_op, raw_pins: req_raw_pins, no_filter: req_no_filter,
                         query_button: req_query_button, query_level: req_query_level};
      end
      if (s1_valid_ff && s2_load) begin
         rsp_level_ff <= level_in;
         rsp_rise_ff  <= rise_in;
         rsp_fall_ff  <= fall_in;
         rsp_lp_ff    <= lp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level_bits = rsp_level_ff;
   assign rsp_rise_bits  = rsp_rise_ff;
   assign rsp_fall_bits  = rsp_fall_ff;
   assign rsp_long_press = rsp_lp_ff;

   // Checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty input stage");

   a_edges_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_rise_bits & rsp_fall_bits) == '0))
      else $error("button reported rising and falling at once");

   a_edge_clears_count: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load && changed[0]) |=> (count_ff[0] == '0))
      else $error("edge did not clear elapsed counter");

   a_tick_keeps_level: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load && s1_item_ff.op == OP_TICK) |=> $stable(level_ff))
      else $error("tick beat changed debounced level");

endmodule
